### hw/rtl/bole_pkg.sv
// ----------------------------------------------------------------------------
// Bounded ordered list package
// Request and result words, request and status codes, and the command and
// status groups that pass between the list controller and its datapath.
// ----------------------------------------------------------------------------
package bole_pkg;

    typedef enum logic [2:0] {
        REQ_INS_TAIL = 3'd0,
        REQ_INS_HEAD = 3'd1,
        REQ_INS_POS  = 3'd2,
        REQ_DEL_VAL  = 3'd3,
        REQ_DEL_HEAD = 3'd4,
        REQ_DEL_TAIL = 3'd5,
        REQ_DEL_POS  = 3'd6,
        REQ_READ_POS = 3'd7
    } t_req_type;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_INS  = 3'd1,
        OP_DEL  = 3'd2,
        OP_FIND = 3'd3,
        OP_READ = 3'd4
    } t_op;

    typedef struct packed {
        t_req_type          req_type;
        logic signed [31:0] item_value;
        logic [7:0]         position;
    } t_request;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] data_out;
        logic [4:0]         entry_count;
        logic               is_empty;
        logic signed [31:0] head_value;
        logic signed [31:0] tail_value;
    } t_result;

    typedef struct packed {
        logic load;
        logic ins;
        logic del;
        logic find;
        logic rd;
        logic snap0;
        logic snap1;
        logic finish;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic step_done;
        logic found;
    } t_stat;

endpackage

### hw/rtl/bole_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/bole_dp.sv
// ----------------------------------------------------------------------------
// Bounded ordered list datapath
// Request checks, entry store, shift and search cursor, and result register.
// ----------------------------------------------------------------------------
module bole_dp import bole_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_request i_req,
    input  t_cmd     i_cmd,
    output t_stat    o_stat,
    output logic     o_done,
    output t_result  o_result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]      r_count;
    logic               r_done;
    logic               r_pend;
    logic               r_pfirst;
    logic [CW-1:0]      r_cur;
    logic [AW-1:0]      r_at;
    logic [AW-1:0]      r_waddr;
    logic [31:0]        r_val;
    t_status            r_status;
    logic [31:0]        r_data;
    logic [31:0]        r_head;
    t_result            r_result;

    logic [CW-1:0]      n_count;
    logic               n_done;
    logic               n_pend;

    logic [8:0]         pos9;
    logic [8:0]         cnt9;
    logic               full;
    logic               empty;
    logic               ins_bad;
    logic               acc_bad;
    logic [AW-1:0]      pos_idx;
    logic [AW-1:0]      cnt_idx;
    logic [AW-1:0]      last_idx;
    t_op                l_op;
    t_status            l_status;
    logic [AW-1:0]      l_at;

    logic [CW-1:0]      cur_at;
    logic               ins_issue;
    logic               ins_done;
    logic               scan_issue;
    logic               scan_done;
    logic               match;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [31:0]        ram_rdata;

    // Request checks against the current count.
    assign pos9     = {1'b0, i_req.position};
    assign cnt9     = 9'(r_count);
    assign full     = (r_count == CW'(CAPACITY));
    assign empty    = (r_count == '0);
    assign ins_bad  = (pos9 == 9'd0) || (pos9 > (cnt9 + 9'd1));
    assign acc_bad  = (pos9 == 9'd0) || (pos9 > cnt9);
    assign pos_idx  = AW'(i_req.position - 8'd1);
    assign cnt_idx  = AW'(r_count);
    assign last_idx = AW'(r_count - CW'(1));

    always_comb begin
        l_op     = OP_NONE;
        l_status = ST_OK;
        l_at     = '0;
        case (i_req.req_type)
            REQ_INS_TAIL: begin
                if (full) begin
                    l_status = ST_FULL;
                end else begin
                    l_op = OP_INS;
                    l_at = cnt_idx;
                end
            end
            REQ_INS_HEAD: begin
                if (full) begin
                    l_status = ST_FULL;
                end else begin
                    l_op = OP_INS;
                end
            end
            REQ_INS_POS: begin
                if (ins_bad) begin
                    l_status = ST_BADPOS;
                end else if (full) begin
                    l_status = ST_FULL;
                end else begin
                    l_op = OP_INS;
                    l_at = pos_idx;
                end
            end
            REQ_DEL_VAL: begin
                if (empty) begin
                    l_status = ST_EMPTY;
                end else begin
                    l_op = OP_FIND;
                end
            end
            REQ_DEL_HEAD: begin
                if (empty) begin
                    l_status = ST_EMPTY;
                end else begin
                    l_op = OP_DEL;
                end
            end
            REQ_DEL_TAIL: begin
                if (empty) begin
                    l_status = ST_EMPTY;
                end else begin
                    l_op = OP_DEL;
                    l_at = last_idx;
                end
            end
            REQ_DEL_POS, REQ_READ_POS: begin
                if (empty) begin
                    l_status = ST_EMPTY;
                end else if (acc_bad) begin
                    l_status = ST_BADPOS;
                end else begin
                    l_op = (i_req.req_type == REQ_DEL_POS) ? OP_DEL : OP_READ;
                    l_at = pos_idx;
                end
            end
            default: begin
                l_op = OP_NONE;
            end
        endcase
    end

    // Cursor conditions. Reads are pipelined one ahead of the writes they feed.
    assign cur_at     = CW'(r_at);
    assign ins_issue  = (r_cur > cur_at);
    assign ins_done   = (r_cur == cur_at) && !r_pend;
    assign scan_issue = (r_cur < r_count);
    assign scan_done  = !scan_issue && !r_pend;
    assign match      = r_pend && (ram_rdata == r_val);

    always_comb begin
        o_stat.op        = l_op;
        o_stat.found     = i_cmd.find && match;
        o_stat.step_done = 1'b0;
        if (i_cmd.ins) begin
            o_stat.step_done = ins_done;
        end else if (i_cmd.del || i_cmd.find) begin
            o_stat.step_done = scan_done;
        end else if (i_cmd.rd) begin
            o_stat.step_done = r_pend;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_waddr;
        ram_wdata = ram_rdata;
        ram_raddr = '0;
        if (i_cmd.ins) begin
            ram_raddr = AW'(r_cur - CW'(1));
            if (r_pend) begin
                ram_we = 1'b1;
            end else if (ins_done) begin
                ram_we    = 1'b1;
                ram_waddr = r_at;
                ram_wdata = r_val;
            end
        end else if (i_cmd.del) begin
            ram_raddr = AW'(r_cur);
            // The first word read is the removed entry, not a shift.
            ram_we    = r_pend && !r_pfirst;
        end else if (i_cmd.find) begin
            ram_raddr = AW'(r_cur);
        end else if (i_cmd.rd) begin
            ram_raddr = r_at;
        end else if (i_cmd.snap0) begin
            // The head entry always sits at index zero.
            ram_raddr = '0;
        end else if (i_cmd.snap1) begin
            ram_raddr = last_idx;
        end
    end

    bole_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_count = r_count;
        n_pend  = r_pend;
        n_done  = i_cmd.finish;
        if (i_cmd.load) begin
            n_pend = 1'b0;
        end else if (i_cmd.ins) begin
            n_pend = ins_issue;
            if (ins_done) begin
                n_count = r_count + CW'(1);
            end
        end else if (i_cmd.del) begin
            n_pend = scan_issue;
            if (scan_done) begin
                n_count = r_count - CW'(1);
            end
        end else if (i_cmd.find) begin
            n_pend = match ? 1'b0 : scan_issue;
        end else if (i_cmd.rd) begin
            n_pend = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val    <= i_req.item_value;
            r_at     <= l_at;
            r_status <= l_status;
            r_data   <= '0;
            case (l_op)
                OP_INS:  r_cur <= r_count;
                OP_FIND: r_cur <= '0;
                default: r_cur <= CW'(l_at);
            endcase
        end else if (i_cmd.ins) begin
            if (ins_issue) begin
                r_cur   <= r_cur - CW'(1);
                r_waddr <= AW'(r_cur);
            end
        end else if (i_cmd.del) begin
            if (scan_issue) begin
                r_cur    <= r_cur + CW'(1);
                r_waddr  <= AW'(r_cur - CW'(1));
                r_pfirst <= (r_cur == cur_at);
            end
            if (r_pend && r_pfirst) begin
                r_data <= ram_rdata;
            end
        end else if (i_cmd.find) begin
            if (match) begin
                // Restart at the matching entry as a delete at that index.
                r_at  <= r_waddr;
                r_cur <= CW'(r_waddr);
            end else begin
                if (scan_issue) begin
                    r_cur   <= r_cur + CW'(1);
                    r_waddr <= AW'(r_cur);
                end
                if (scan_done) begin
                    r_status <= ST_NOTFOUND;
                end
            end
        end else if (i_cmd.rd) begin
            if (r_pend) begin
                r_data <= ram_rdata;
            end
        end else if (i_cmd.snap1) begin
            r_head <= ram_rdata;
        end
        if (i_cmd.finish) begin
            r_result.status      <= r_status;
            r_result.data_out    <= r_data;
            r_result.entry_count <= 5'(r_count);
            r_result.is_empty    <= empty;
            r_result.head_value  <= empty ? '0 : r_head;
            r_result.tail_value  <= empty ? '0 : ram_rdata;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

### hw/rtl/bole_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded ordered list controller
// Sequences one request: check, shift or search, head and tail read, result.
// ----------------------------------------------------------------------------
module bole_ctrl import bole_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_INS   = 8'b0000_0010,
        S_DEL   = 8'b0000_0100,
        S_FIND  = 8'b0000_1000,
        S_RD    = 8'b0001_0000,
        S_SNAP0 = 8'b0010_0000,
        S_SNAP1 = 8'b0100_0000,
        S_SNAP2 = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_stat.op)
                        OP_INS:  n_state = S_INS;
                        OP_DEL:  n_state = S_DEL;
                        OP_FIND: n_state = S_FIND;
                        OP_READ: n_state = S_RD;
                        default: n_state = S_SNAP0;
                    endcase
                end
            end
            S_INS, S_DEL, S_RD: begin
                if (i_stat.step_done) begin
                    n_state = S_SNAP0;
                end
            end
            S_FIND: begin
                if (i_stat.found) begin
                    n_state = S_DEL;
                end else if (i_stat.step_done) begin
                    n_state = S_SNAP0;
                end
            end
            S_SNAP0: n_state = S_SNAP1;
            S_SNAP1: n_state = S_SNAP2;
            S_SNAP2: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_cmd.load   = (r_state == S_IDLE) && i_start;
    assign o_cmd.ins    = (r_state == S_INS);
    assign o_cmd.del    = (r_state == S_DEL);
    assign o_cmd.find   = (r_state == S_FIND);
    assign o_cmd.rd     = (r_state == S_RD);
    assign o_cmd.snap0  = (r_state == S_SNAP0);
    assign o_cmd.snap1  = (r_state == S_SNAP1);
    assign o_cmd.finish = (r_state == S_SNAP2);

endmodule

### hw/rtl/bounded_ordered_list_engine.sv
// ----------------------------------------------------------------------------
// Bounded ordered list engine
// Keeps up to CAPACITY signed 32-bit entries in order and serves one insert,
// delete or read request at a time, answering each with one result word.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low; busy stays high
// until the result word has been registered, and the result is shown for one
// cycle with o_done, which the receiver must take as it comes. A rejected
// request goes straight to the head and tail read. An insert at index k
// shifts the entries from k on up and a delete at k shifts those after k
// down, one entry per cycle through the single write port of the entry RAM;
// an append shifts nothing. A delete by value scans from the head and on a
// match deletes at that index; a read fetches one entry. Each request ends
// in S_SNAP0, S_SNAP1 and S_SNAP2, reading the head and tail entries back
// from the RAM. A new request can be taken in the cycle the result is shown.
module bounded_ordered_list_engine import bole_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_request i_req,
    output logic     busy,
    output logic     o_done,
    output t_result  o_result
);

    t_cmd  cmd;
    t_stat stat;

    bole_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    bole_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule
